// ===== src/xts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XYZ to sRGB package
// Types, fixed-point constants, the D65 matrix and the gamma curve table
// shared by the pixel converter and its channel encoders.
// ----------------------------------------------------------------------------
package xts_pkg;

   // Curve table resolution and matrix coefficient precision.
   localparam int GAMMA_SEGMENTS = 256;
   localparam int COEF_FRAC_BITS = 16;

   // Curve layout: PER_OCT segments in each of the nine octaves [2^-9, 1].
   localparam int PER_OCT  = GAMMA_SEGMENTS / 9;
   localparam int KNOTS    = 9 * PER_OCT + 1;
   localparam int KIDX_W   = $clog2(KNOTS);
   localparam int KF_W     = KIDX_W + 1;
   localparam int J_W      = $clog2(PER_OCT);
   localparam int T_W      = 24 + $clog2(PER_OCT + 1);
   localparam int CURVE_W  = 25;
   localparam int FRAC_W   = 23;
   localparam int OCT_W    = 4;
   localparam int H_W      = 5;
   localparam int H_BASE   = 15;
   localparam int IPROD_W  = CURVE_W + FRAC_W;
   localparam int E_W      = CURVE_W + 1;

   // Matrix arithmetic widths.
   localparam int COEF_W    = COEF_FRAC_BITS + 3;
   localparam int PROD_W    = COEF_W + 17;
   localparam int ACC_W     = PROD_W + 2;
   localparam int LIN_SHIFT = COEF_FRAC_BITS - 9;
   localparam int LIN_RAW_W = ACC_W - LIN_SHIFT;
   localparam int LIN_W     = 25;
   localparam longint LIN_RND = longint'(1) << (COEF_FRAC_BITS - 10);
   localparam longint ONE24   = longint'(1) << 24;

   // Linear segment: value <= 0.0031308 in Q24, out = floor(floor(N / 2^24) / 25).
   localparam longint COEF_DEN    = 10000000;
   localparam longint LIN_KNEE    = (longint'(31308) << 24) / COEF_DEN;
   localparam int     Q1_W        = 17;
   localparam int     LNUM_W      = 41;
   localparam logic [24:0] LIN_MUL = 25'(323 * 65535);
   localparam longint LIN_ADD     = longint'(25) << 23;
   localparam int     RECIP_SHIFT = 22;
   localparam logic [17:0] RECIP_25 = 18'(((longint'(1) << RECIP_SHIFT) + 24) / 25);
   localparam int     QM_W        = Q1_W + 18;

   localparam longint CURVE_DEN = 64000;

   localparam int PIPE_STAGES = 8;
   localparam int ENC_STAGES  = 6;
   localparam int CHANNELS    = 3;

   typedef struct packed {
      logic [15:0] x_tristimulus;
      logic [15:0] y_tristimulus;
      logic [15:0] z_tristimulus;
   } xyz_pixel_type;

   typedef struct packed {
      logic [15:0] red_encoded;
      logic [15:0] green_encoded;
      logic [15:0] blue_encoded;
      logic [2:0]  clip_mask;
   } srgb_pixel_type;

   typedef enum logic [1:0] {
      CLS_NEG,
      CLS_OVER,
      CLS_LINEAR,
      CLS_CURVE
   } chan_class_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [CURVE_W-1:0] curve_entry_type;
   typedef curve_entry_type curve_table_type [KNOTS];

   // Coefficient rounded half away from zero from its seven-decimal value.
   function automatic coef_type coef_fixed(longint c7);
      longint mag;
      longint r;
      mag = (c7 < 0) ? -c7 : c7;
      r = ((mag << COEF_FRAC_BITS) + COEF_DEN / 2) / COEF_DEN;
      return (c7 < 0) ? coef_type'(-r) : coef_type'(r);
   endfunction

   localparam coef_type COEF_TABLE [9] = '{
      coef_fixed(32404542), coef_fixed(-15371385), coef_fixed(-4985314),
      coef_fixed(-9692660), coef_fixed(18760108),  coef_fixed(415560),
      coef_fixed(556434),   coef_fixed(-2040259),  coef_fixed(10572252)
   };

   // Twelfth power in Q30 by eleven truncated products.
   function automatic longint unsigned pow12_q30(longint unsigned w);
      longint unsigned p;
      p = w;
      for (int i = 0; i < 11; i++) begin
         p = (p * w) >> 30;
      end
      return p;
   endfunction

   function automatic longint round_curve(longint n);
      if (n >= 0) begin
         return (n + CURVE_DEN / 2) / CURVE_DEN;
      end
      return -((-n + CURVE_DEN / 2) / CURVE_DEN);
   endfunction

   // Encoded curve value in Q24 at every knot, 1.055*v^(1/2.4)-0.055.
   function automatic curve_table_type build_curve();
      curve_table_type tbl;
      longint unsigned h;
      longint unsigned j;
      longint unsigned vq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned y;
      longint num;
      for (int n = 0; n < KNOTS; n++) begin
         h  = 64'(H_BASE + n / PER_OCT);
         j  = 64'(n % PER_OCT);
         vq = ((64'(PER_OCT) + j) << (h + 6)) / 64'(PER_OCT);
         lo = 0;
         hi = 64'd1 << 30;
         for (int it = 0; it < 32; it++) begin
            if (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               if (pow12_q30(mid) <= vq) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         y = lo;
         for (int i = 0; i < 4; i++) begin
            y = (y * lo) >> 30;
         end
         num = longint'(64'd1055 * y) - (longint'(55) << 30);
         tbl[n] = CURVE_W'(round_curve(num));
      end
      return tbl;
   endfunction

   localparam curve_table_type CURVE = build_curve();

endpackage
`default_nettype wire

// ===== src/xts_encode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XYZ to sRGB channel encoder
// Six-stage pipeline that turns one linear matrix sum into a clipped,
// gamma-encoded 16-bit channel value and its clip flag.
// ----------------------------------------------------------------------------
module xts_encode
   import xts_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [ENC_STAGES-1:0]   stage_en,
   input  wire logic signed [ACC_W-1:0] acc,
   output logic [15:0]                  value,
   output logic                         clip
);

   // Stage 3: round to Q24 and classify.
   logic [ACC_W-1:0]     rnd_sum;
   logic [LIN_RAW_W-1:0] lin_raw;
   chan_class_type       s3_cls_in, s3_cls_ff;
   logic [LIN_W-1:0]     s3_lin_in, s3_lin_ff;

   assign rnd_sum   = $unsigned(acc) + ACC_W'(LIN_RND);
   assign lin_raw   = LIN_RAW_W'(rnd_sum >> LIN_SHIFT);
   assign s3_lin_in = lin_raw[LIN_W-1:0];

   always_comb begin
      if (acc[ACC_W-1]) begin
         s3_cls_in = CLS_NEG;
      end else if (lin_raw > LIN_RAW_W'(ONE24)) begin
         s3_cls_in = CLS_OVER;
      end else if (lin_raw <= LIN_RAW_W'(LIN_KNEE)) begin
         s3_cls_in = CLS_LINEAR;
      end else begin
         s3_cls_in = CLS_CURVE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s3_cls_ff <= s3_cls_in;
         s3_lin_ff <= s3_lin_in;
      end
   end

   // Stage 4: linear-segment product and curve segment index.
   logic [LNUM_W-1:0] lin_num;
   logic [OCT_W-1:0]  oct_c;
   logic [H_W-1:0]    h_c;
   logic [23:0]       m_c;
   logic [T_W-1:0]    t_c;
   logic [J_W-1:0]    j_c;
   logic [KF_W-1:0]   kf_c;

   logic [Q1_W-1:0]   s4_q1_in, s4_q1_ff;
   logic [KIDX_W-1:0] s4_k_in, s4_k_ff;
   logic [FRAC_W-1:0] s4_f_in, s4_f_ff;
   logic [OCT_W-1:0]  s4_oct_ff;
   logic              s4_one_in, s4_one_ff;
   chan_class_type    s4_cls_ff;

   assign lin_num  = LNUM_W'(s3_lin_ff[15:0]) * LNUM_W'(LIN_MUL) + LNUM_W'(LIN_ADD);
   assign s4_q1_in = lin_num[LNUM_W-1:24];

   // Octave: top set bit of the value, which lies in bits 15 to 23 here.
   always_comb begin
      oct_c = '0;
      for (int i = 0; i < 9; i++) begin
         if (s3_lin_ff[H_BASE + i]) begin
            oct_c = OCT_W'(i);
         end
      end
   end

   assign h_c       = H_W'(oct_c) + H_W'(H_BASE);
   assign m_c       = s3_lin_ff[23:0] & ~(24'd1 << h_c);
   assign t_c       = T_W'(m_c) * T_W'(PER_OCT);
   assign j_c       = J_W'(t_c >> h_c);
   assign s4_f_in   = FRAC_W'(t_c & ((T_W'(1) << h_c) - T_W'(1)));
   assign kf_c      = KF_W'(oct_c) * KF_W'(PER_OCT) + KF_W'(j_c);
   assign s4_k_in   = (kf_c > KF_W'(KNOTS - 2)) ? KIDX_W'(KNOTS - 2) : KIDX_W'(kf_c);
   assign s4_one_in = s3_lin_ff[24];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s4_q1_ff  <= s4_q1_in;
         s4_k_ff   <= s4_k_in;
         s4_f_ff   <= s4_f_in;
         s4_oct_ff <= oct_c;
         s4_one_ff <= s4_one_in;
         s4_cls_ff <= s3_cls_ff;
      end
   end

   // Stage 5: reciprocal multiply for the divide by 25, curve table lookup.
   logic [QM_W-1:0]    s5_qm_in, s5_qm_ff;
   logic [CURVE_W-1:0] s5_base_in, s5_base_ff;
   logic [CURVE_W-1:0] s5_diff_in, s5_diff_ff;
   logic [FRAC_W-1:0]  s5_f_ff;
   logic [OCT_W-1:0]   s5_oct_ff;
   chan_class_type     s5_cls_ff;

   assign s5_qm_in = QM_W'(s4_q1_ff) * QM_W'(RECIP_25);

   always_comb begin
      if (s4_one_ff) begin
         s5_base_in = CURVE[KNOTS - 1];
         s5_diff_in = '0;
      end else begin
         s5_base_in = CURVE[s4_k_ff];
         s5_diff_in = CURVE[KIDX_W'(s4_k_ff + 1'b1)] - CURVE[s4_k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s5_qm_ff   <= s5_qm_in;
         s5_base_ff <= s5_base_in;
         s5_diff_ff <= s5_diff_in;
         s5_f_ff    <= s4_f_ff;
         s5_oct_ff  <= s4_oct_ff;
         s5_cls_ff  <= s4_cls_ff;
      end
   end

   // Stage 6: interpolation product; linear result is ready.
   logic [IPROD_W-1:0] s6_prod_in, s6_prod_ff;
   logic [15:0]        s6_lout_in, s6_lout_ff;
   logic [CURVE_W-1:0] s6_base_ff;
   logic [OCT_W-1:0]   s6_oct_ff;
   chan_class_type     s6_cls_ff;

   assign s6_prod_in = IPROD_W'(s5_diff_ff) * IPROD_W'(s5_f_ff);
   assign s6_lout_in = 16'(s5_qm_ff >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s6_prod_ff <= s6_prod_in;
         s6_lout_ff <= s6_lout_in;
         s6_base_ff <= s5_base_ff;
         s6_oct_ff  <= s5_oct_ff;
         s6_cls_ff  <= s5_cls_ff;
      end
   end

   // Stage 7: rounded shift of the product and add to the knot value.
   logic [H_W-1:0]       h7;
   logic [IPROD_W:0]     rnd_prod;
   logic [E_W-1:0]       s7_e_in, s7_e_ff;
   logic [15:0]          s7_lout_ff;
   chan_class_type       s7_cls_ff;

   assign h7       = H_W'(s6_oct_ff) + H_W'(H_BASE);
   assign rnd_prod = (IPROD_W + 1)'(s6_prod_ff) + ((IPROD_W + 1)'(1) << (h7 - H_W'(1)));
   assign s7_e_in  = E_W'(s6_base_ff) + E_W'(rnd_prod >> h7);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s7_e_ff    <= s7_e_in;
         s7_lout_ff <= s6_lout_ff;
         s7_cls_ff  <= s6_cls_ff;
      end
   end

   // Stage 8: scale Q24 to 16 bits and select the result by class.
   logic [E_W+16:0] gscaled;
   logic [E_W+16:0] gshift;
   logic [15:0]     gval;
   logic [15:0]     s8_value_in, s8_value_ff;
   logic            s8_clip_in, s8_clip_ff;

   assign gscaled = ((E_W + 17)'(s7_e_ff) << 16) - (E_W + 17)'(s7_e_ff)
                    + ((E_W + 17)'(1) << 23);
   assign gshift  = gscaled >> 24;
   assign gval    = (gshift > (E_W + 17)'(16'hFFFF)) ? 16'hFFFF : gshift[15:0];

   always_comb begin
      case (s7_cls_ff)
         CLS_NEG: begin
            s8_value_in = 16'h0000;
            s8_clip_in  = 1'b1;
         end
         CLS_OVER: begin
            s8_value_in = 16'hFFFF;
            s8_clip_in  = 1'b1;
         end
         CLS_LINEAR: begin
            s8_value_in = s7_lout_ff;
            s8_clip_in  = 1'b0;
         end
         default: begin
            s8_value_in = gval;
            s8_clip_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s8_value_ff <= s8_value_in;
         s8_clip_ff  <= s8_clip_in;
      end
   end

   assign value = s8_value_ff;
   assign clip  = s8_clip_ff;

endmodule
`default_nettype wire

// ===== src/xyz_to_srgb_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XYZ to sRGB pixel converter
// Converts one CIE XYZ pixel per cycle to gamma-encoded, clipped sRGB (D65).
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one XYZ item (three unsigned Q15 tristimulus
//   values) and the rsp channel one sRGB item (three 16-bit encoded channels,
//   full scale 65535, plus a three-bit clip mask, red in bit 0). An item moves
//   on an edge where its valid is high and its stall is low.
//   The pipeline has eight register stages: the matrix products, the row
//   sums, then six stages per channel for rounding and classification, the
//   curve segment index, the curve table lookup, the interpolation multiply,
//   the interpolation add, and the final scaling and selection. An item
//   accepted at one edge passes through every stage in order before it is
//   offered on rsp. While rsp does not stall, one item can enter every
//   cycle, so the sustained rate is one item per clock.
//   Reset clears all stage valid bits; data registers are not reset.
//   Each stage advances when the stage after it is empty or advancing, so a
//   stall on rsp holds only the stages that carry items: empty stages keep
//   filling, and req_stall rises only when all eight stages are occupied and
//   the receiver is stalling.
// ----------------------------------------------------------------------------
module xyz_to_srgb_pixel
   import xts_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,

   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire xyz_pixel_type  req_item,

   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output srgb_pixel_type      rsp_item
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] stage_en;

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      stage_en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int s = PIPE_STAGES - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign valid_in  = {valid_ff[PIPE_STAGES-2:0], req_valid};
   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < PIPE_STAGES; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Stage 1: the nine coefficient products, taken straight from the input.
   logic [15:0]              comp [CHANNELS];
   logic signed [PROD_W-1:0] s1_prod_in [CHANNELS][CHANNELS];
   logic signed [PROD_W-1:0] s1_prod_ff [CHANNELS][CHANNELS];

   assign comp[0] = req_item.x_tristimulus;
   assign comp[1] = req_item.y_tristimulus;
   assign comp[2] = req_item.z_tristimulus;

   always_comb begin
      for (int r = 0; r < CHANNELS; r++) begin
         for (int i = 0; i < CHANNELS; i++) begin
            s1_prod_in[r][i] = PROD_W'(COEF_TABLE[r * CHANNELS + i])
                               * PROD_W'($signed({1'b0, comp[i]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Stage 2: one exact row sum per output channel.
   logic signed [ACC_W-1:0] s2_acc_in [CHANNELS];
   logic signed [ACC_W-1:0] s2_acc_ff [CHANNELS];

   always_comb begin
      for (int r = 0; r < CHANNELS; r++) begin
         s2_acc_in[r] = ACC_W'(s1_prod_ff[r][0]) + ACC_W'(s1_prod_ff[r][1])
                        + ACC_W'(s1_prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_acc_ff <= s2_acc_in;
      end
   end

   // Stages 3 to 8: one encoder per channel.
   logic [15:0]         enc_value [CHANNELS];
   logic [CHANNELS-1:0] enc_clip;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      xts_encode u_enc (
         .clock    (clock),
         .stage_en (stage_en[PIPE_STAGES-1:PIPE_STAGES-ENC_STAGES]),
         .acc      (s2_acc_ff[c]),
         .value    (enc_value[c]),
         .clip     (enc_clip[c])
      );
   end

   always_comb begin
      rsp_item.red_encoded   = enc_value[0];
      rsp_item.green_encoded = enc_value[1];
      rsp_item.blue_encoded  = enc_value[2];
      rsp_item.clip_mask     = enc_clip;
   end

`ifndef SYNTH
   // An accepted item always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   // The input is held off only when every stage carries an item.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while the pipeline had a free stage");

   // A clipped channel reads as zero or full scale.
   a_clip_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((!rsp_item.clip_mask[0] || rsp_item.red_encoded == 16'h0000
           || rsp_item.red_encoded == 16'hFFFF)
          && (!rsp_item.clip_mask[1] || rsp_item.green_encoded == 16'h0000
           || rsp_item.green_encoded == 16'hFFFF)
          && (!rsp_item.clip_mask[2] || rsp_item.blue_encoded == 16'h0000
           || rsp_item.blue_encoded == 16'hFFFF)))
      else $error("clipped channel is neither zero nor full scale");
`endif

endmodule
`default_nettype wire

// ===== dv/xts_pixel_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XYZ to sRGB pixel checker
// Watches both channels of the converter, computes the expected sRGB item for
// every accepted XYZ item and compares each returned item in order.
// ----------------------------------------------------------------------------
module xts_pixel_checker
   import xts_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_stall,
   input  wire xyz_pixel_type  req_item,
   input  wire logic           rsp_valid,
   input  wire logic           rsp_stall,
   input  wire srgb_pixel_type rsp_item,
   input  wire logic           end_of_test,
   output int                  fail_count,
   output int                  expected_count
);

   localparam int     OCT_SEGS   = GAMMA_SEGMENTS / 9;
   localparam int     KNOT_COUNT = 9 * OCT_SEGS + 1;
   localparam longint Q24_ONE    = longint'(1) << 24;
   localparam longint Q30_ONE    = longint'(1) << 30;
   localparam longint CODE_MAX   = 65535;

   longint         knot_code [KNOT_COUNT];
   longint         mat_coef [9];
   srgb_pixel_type srgb_q [$];
   srgb_pixel_type wanted;
   int             result_count;
   logic           leftover_done;

   // D65 XYZ to linear sRGB matrix, row major, in units of 1e-7.
   function automatic longint d65_e7(int idx);
      case (idx)
         0: return 32404542;
         1: return -15371385;
         2: return -4985314;
         3: return -9692660;
         4: return 18760108;
         5: return 415560;
         6: return 556434;
         7: return -2040259;
         default: return 10572252;
      endcase
   endfunction

   function automatic longint round_away(longint num, longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint unsigned twelfth_power(longint unsigned w);
      longint unsigned p;
      p = w;
      repeat (11) begin
         p = (p * w) >> 30;
      end
      return p;
   endfunction

   // Returns {clipped, code} for one output channel.
   function automatic logic [16:0] encode_row(int row, xyz_pixel_type px);
      longint acc;
      longint lin;
      longint e;
      longint code;
      longint m;
      longint t;
      longint f;
      longint base;
      longint diff;
      longint val;
      int     h;
      int     k;
      acc = mat_coef[row*3] * longint'(px.x_tristimulus)
          + mat_coef[row*3+1] * longint'(px.y_tristimulus)
          + mat_coef[row*3+2] * longint'(px.z_tristimulus);
      if (acc < 0) begin
         return {1'b1, 16'd0};
      end
      lin = (acc + (longint'(1) << (COEF_FRAC_BITS - 10))) >>> (COEF_FRAC_BITS - 9);
      if (lin > Q24_ONE) begin
         return {1'b1, 16'hFFFF};
      end
      if (lin * 10000000 <= 31308 * Q24_ONE) begin
         code = (lin * 1292 * 65535 + 50 * Q24_ONE) / (100 * Q24_ONE);
         return {1'b0, code[15:0]};
      end
      if (lin == Q24_ONE) begin
         e = knot_code[KNOT_COUNT-1];
      end else begin
         h = 23;
         while (h > 15 && lin[h] == 1'b0) begin
            h--;
         end
         m = lin - (longint'(1) << h);
         t = m * OCT_SEGS;
         f = t & ((longint'(1) << h) - 1);
         k = (h - 15) * OCT_SEGS + int'(t >>> h);
         if (k >= KNOT_COUNT - 1) begin
            k = KNOT_COUNT - 2;
         end
         base = knot_code[k];
         diff = knot_code[k+1] - base;
         val  = base + ((diff * f + (longint'(1) << (h - 1))) >>> h);
         e    = (val < 0) ? 0 : val;
      end
      code = (e * 65535 + (longint'(1) << 23)) >>> 24;
      if (code > CODE_MAX) begin
         code = CODE_MAX;
      end
      return {1'b0, code[15:0]};
   endfunction

   function automatic srgb_pixel_type predict_srgb(xyz_pixel_type px);
      srgb_pixel_type res;
      logic [16:0]    r;
      logic [16:0]    g;
      logic [16:0]    b;
      r = encode_row(0, px);
      g = encode_row(1, px);
      b = encode_row(2, px);
      res.red_encoded   = r[15:0];
      res.green_encoded = g[15:0];
      res.blue_encoded  = b[15:0];
      res.clip_mask     = {b[16], g[16], r[16]};
      return res;
   endfunction

   task automatic note_failure(input string what);
      if (fail_count < 10) begin
         $display("%s", what);
      end
      fail_count++;
   endtask

   // Matrix coefficients and the gamma knots are built once at time zero.
   initial begin : build_tables
      longint unsigned hh;
      longint unsigned jj;
      longint unsigned vq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned y;
      longint          mag;
      fail_count     = 0;
      expected_count = 0;
      result_count   = 0;
      leftover_done  = 1'b0;
      for (int i = 0; i < 9; i++) begin
         mag = (d65_e7(i) < 0) ? -d65_e7(i) : d65_e7(i);
         mag = ((mag << COEF_FRAC_BITS) + 5000000) / 10000000;
         mat_coef[i] = (d65_e7(i) < 0) ? -mag : mag;
      end
      for (int n = 0; n < KNOT_COUNT; n++) begin
         hh = 64'(15 + n / OCT_SEGS);
         jj = 64'(n % OCT_SEGS);
         vq = ((64'(OCT_SEGS) + jj) << (hh + 6)) / 64'(OCT_SEGS);
         lo = 0;
         hi = Q30_ONE;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (twelfth_power(mid) <= vq) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         y = lo;
         repeat (4) begin
            y = (y * lo) >> 30;
         end
         knot_code[n] = round_away(longint'(1055 * y) - 55 * Q30_ONE, 64000);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            srgb_q.push_back(predict_srgb(req_item));
         end
         if (rsp_valid && !rsp_stall) begin
            if (srgb_q.size() == 0) begin
               note_failure($sformatf("result %0d arrived with no item outstanding: %h",
                                      result_count, rsp_item));
            end else begin
               wanted = srgb_q.pop_front();
               if (rsp_item.red_encoded !== wanted.red_encoded ||
                   rsp_item.green_encoded !== wanted.green_encoded ||
                   rsp_item.blue_encoded !== wanted.blue_encoded ||
                   rsp_item.clip_mask !== wanted.clip_mask) begin
                  note_failure($sformatf(
                     "result %0d mismatch: expected r=%h g=%h b=%h mask=%b, got r=%h g=%h b=%h mask=%b",
                     result_count, wanted.red_encoded, wanted.green_encoded,
                     wanted.blue_encoded, wanted.clip_mask, rsp_item.red_encoded,
                     rsp_item.green_encoded, rsp_item.blue_encoded, rsp_item.clip_mask));
               end
            end
            result_count++;
         end
         if (end_of_test && !leftover_done) begin
            leftover_done = 1'b1;
            if (srgb_q.size() != 0) begin
               note_failure($sformatf("%0d items never produced a result", srgb_q.size()));
            end
         end
      end
      expected_count <= srgb_q.size();
   end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XYZ to sRGB pixel converter testbench
// Drives directed and random XYZ items into the converter under changing
// back pressure and lets a checker compare every sRGB item it returns.
// ----------------------------------------------------------------------------
module tb_top;
   import xts_pkg::*;

   // The run is bounded by this many time units, far beyond the slowest run.
   localparam int unsigned TIMEOUT_TICKS = 4000000;
   // Items per random phase; three phases plus the directed list.
   localparam int PHASE_ITEMS = 195;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD = 64;
   // Cycles to wait after the last result, well past the pipeline depth.
   localparam int TAIL_CYCLES = 4 * PIPE_STAGES;
   // D65 white point in units of 1e-5, relative to Y.
   localparam longint WHITE_X_E5 = 95047;
   localparam longint WHITE_Z_E5 = 108883;

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           req_valid   = 1'b0;
   xyz_pixel_type  req_item    = '0;
   logic           rsp_stall   = 1'b0;
   logic           end_of_test = 1'b0;
   logic           req_stall;
   logic           rsp_valid;
   srgb_pixel_type rsp_item;
   int             fail_count;
   int             expected_count;

   // Idle rates in percent. The sender rate is only used by the stimulus
   // process; the receiver rate is handed to the stall process.
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   logic           hold_go       = 1'b0;
   logic           hold_done     = 1'b0;
   int             hold_left     = 0;

   xyz_to_srgb_pixel u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   xts_pixel_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .end_of_test    (end_of_test),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver. Normally it stalls at random with the current idle rate. Once
   // hold_go is raised it stalls solidly for the long hold-off, counted here
   // in hold_left, so the pipeline fills and the converter has to stall its input.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left + 1;
         if (hold_left == LONG_HOLD - 1) begin
            hold_done <= 1'b1;
         end
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // A gray pixel of the given Y level with the D65 white point ratios, each
   // component moved at random by up to spread codes and kept in range.
   function automatic xyz_pixel_type gray_pixel(longint level, int unsigned spread);
      longint        comp [3];
      xyz_pixel_type px;
      comp[0] = level * WHITE_X_E5 / 100000;
      comp[1] = level;
      comp[2] = level * WHITE_Z_E5 / 100000;
      for (int i = 0; i < 3; i++) begin
         comp[i] = comp[i] + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
         if (comp[i] < 0) begin
            comp[i] = 0;
         end else if (comp[i] > 65535) begin
            comp[i] = 65535;
         end
      end
      px = {comp[0][15:0], comp[1][15:0], comp[2][15:0]};
      return px;
   endfunction

   // Random items. Fully random components mostly land in the clipped
   // regions, so most items are near-neutral colors that keep all three
   // channels on the curve, plus dim ones around the linear-segment knee.
   function automatic xyz_pixel_type random_pixel();
      int unsigned   pick;
      int unsigned   level;
      xyz_pixel_type px;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         px = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else if (pick < 55) begin
         px = gray_pixel(longint'($urandom_range(0, 34000)), 0);
      end else if (pick < 80) begin
         level = $urandom_range(0, 36000);
         px = gray_pixel(longint'(level), level / 6 + 1);
      end else begin
         px = gray_pixel(longint'($urandom_range(0, 400)), 4);
      end
      return px;
   endfunction

   // Offer one item and hold it until accepted, then maybe idle for a few
   // cycles with junk on the payload. This task lowers valid only in idle
   // cycles, so back-to-back items keep it high throughout.
   task automatic send_pixel(input xyz_pixel_type px);
      req_item  <= px;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_item  <= {16'($urandom), 16'($urandom), 16'($urandom)};
         @(posedge clock);
      end
   endtask

   // Stop offering items until every outstanding item has returned.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_phase(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct <= receiver_pct;
      repeat (PHASE_ITEMS) begin
         send_pixel(random_pixel());
      end
   endtask

   initial begin : stimulus
      xyz_pixel_type directed_q [$];
      longint        cx;
      longint        cy;
      longint        cz;
      longint        acc;
      longint        rem;
      longint        zz;
      longint        mag;
      longint        c7 [3];
      longint        coef [3];
      logic          found;
      xyz_pixel_type one_px;

      // Search for an item whose green linear value is exactly one. It uses
      // the green row of the matrix with X small and Y just above one half, and
      // picks Z so that the rounded sum lands on 2^24.
      c7[0] = -9692660;
      c7[1] = 18760108;
      c7[2] = 415560;
      for (int i = 0; i < 3; i++) begin
         mag = (c7[i] < 0) ? -c7[i] : c7[i];
         mag = ((mag << COEF_FRAC_BITS) + 5000000) / 10000000;
         coef[i] = (c7[i] < 0) ? -mag : mag;
      end
      found  = 1'b0;
      one_px = '0;
      for (cx = 0; cx < 256 && !found; cx++) begin
         for (cy = 17000; cy < 18000 && !found; cy++) begin
            rem = (longint'(1) << 31) - 64 - (coef[0] * cx + coef[1] * cy);
            zz  = (rem <= 0) ? 0 : (rem + coef[2] - 1) / coef[2];
            acc = coef[0] * cx + coef[1] * cy + coef[2] * zz;
            if (zz <= 65535 && acc >= (longint'(1) << 31) - 64 &&
                acc < (longint'(1) << 31) + 64) begin
               found  = 1'b1;
               one_px = {cx[15:0], cy[15:0], zz[15:0]};
            end
         end
      end

      // Directed items: black, full scale on each component and on all,
      // white and just above it so channels cross one, tiny values on the
      // linear segment and around its knee, negative sums from a lone
      // component, alternating bit patterns, and the exactly-one item.
      directed_q.push_back({16'h0000, 16'h0000, 16'h0000});
      directed_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
      directed_q.push_back({16'hFFFF, 16'h0000, 16'h0000});
      directed_q.push_back({16'h0000, 16'hFFFF, 16'h0000});
      directed_q.push_back({16'h0000, 16'h0000, 16'hFFFF});
      directed_q.push_back(gray_pixel(32768, 0));
      directed_q.push_back(gray_pixel(16384, 0));
      directed_q.push_back(gray_pixel(33600, 0));
      directed_q.push_back(gray_pixel(1, 0));
      directed_q.push_back({16'h0001, 16'h0001, 16'h0001});
      directed_q.push_back(gray_pixel(100, 0));
      directed_q.push_back(gray_pixel(103, 0));
      directed_q.push_back(gray_pixel(110, 0));
      directed_q.push_back(gray_pixel(3000, 0));
      directed_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
      directed_q.push_back({16'h5555, 16'hAAAA, 16'h5555});
      directed_q.push_back({16'h8000, 16'h8000, 16'h8000});
      directed_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
      if (found) begin
         directed_q.push_back(one_px);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First phase: the sender rarely idles and the receiver often stalls.
      send_idle_pct = 9;
      recv_idle_pct <= 53;
      foreach (directed_q[i]) begin
         send_pixel(directed_q[i]);
      end
      random_phase(9, 53);
      wait_drained();

      // Second phase: the roles swap, so the pipeline mostly runs sparse.
      random_phase(53, 9);
      wait_drained();

      // Third phase: no idling at all, opened by the long receiver hold-off
      // while the sender keeps pushing items at full rate.
      hold_go <= 1'b1;
      random_phase(0, 0);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_TICKS);
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
src/xts_pkg.sv
src/xts_encode.sv
src/xyz_to_srgb_pixel.sv
dv/xts_pixel_checker.sv
dv/tb_top.sv
